FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL file msdt_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/msdt_pkg.sv
// Types and constants of the deadline timer table.
package msdt_pkg;
	localparam int SLOTS  = 16;
	localparam int IDX_W  = 4;
	localparam int TIME_W = 32;
	localparam int TAG_W  = 32;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_RUN    = 3'd2,
		ACT_NEXT   = 3'd3,
		ACT_FIND   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_FOUND  = 2'd2,
		ST_NOT_ACTIVE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic              active;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] period;
		logic [TAG_W-1:0]  tag;
	} slot_t;
endpackage

FILE: hdl/msdt_cell.sv
// One timer slot of the rotating ring.
module msdt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  msdt_pkg::slot_t d,
	output msdt_pkg::slot_t q
);
	logic                       active_q;
	logic [msdt_pkg::TIME_W-1:0] deadline_q;
	logic [msdt_pkg::TIME_W-1:0] period_q;
	logic [msdt_pkg::TAG_W-1:0]  tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift) begin
			active_q <= d.active;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			deadline_q <= d.deadline;
			period_q   <= d.period;
			tag_q      <= d.tag;
		end
	end

	assign q = '{active: active_q, deadline: deadline_q, period: period_q, tag: tag_q};
endmodule

FILE: hdl/msdt_ctrl.sv
// Sequencer: walks the ring head, rewrites slots, keeps the cache, drives results.
`include "assert_macros.svh"
module msdt_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   action,
	input  logic [msdt_pkg::TIME_W-1:0]  now,
	input  logic [msdt_pkg::TIME_W-1:0]  delay,
	input  logic [msdt_pkg::TIME_W-1:0]  period,
	input  logic [msdt_pkg::IDX_W-1:0]   slot,
	input  logic [msdt_pkg::TAG_W-1:0]   tag,
	input  msdt_pkg::slot_t              head,
	output msdt_pkg::slot_t              wb,
	output logic                         shift,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         fired,
	output logic [msdt_pkg::IDX_W-1:0]   slot_out,
	output logic [msdt_pkg::TAG_W-1:0]   tag_out,
	output logic [msdt_pkg::TIME_W-1:0]  next_deadline,
	output logic                         deadline_valid,
	output logic                         last
);
	localparam int TW = msdt_pkg::TIME_W;
	localparam int IW = msdt_pkg::IDX_W;

	msdt_pkg::state_t state_q, state_d;
	logic [2:0]    act_q;
	logic [TW-1:0] now_q, dl_q, period_q, min_q, cache_q;
	logic [IW-1:0] sel_q, cnt_q, idx_q;
	logic [msdt_pkg::TAG_W-1:0] tag_q;
	logic found_q, fired_any_q, cache_v_q;

	logic out_valid_q, fired_q, dv_q, last_q;
	logic [1:0] status_q;
	logic [IW-1:0] slot_out_q;
	logic [msdt_pkg::TAG_W-1:0] tag_out_q;
	logic [TW-1:0] nd_q;

	logic out_free, accept, step, fire, hit, last_step, emit_final;
	logic [TW:0] dl_sum, rl_sum;
	logic [TW-1:0] reload;
	logic [1:0] f_status;
	logic [IW-1:0] f_slot;
	logic [msdt_pkg::TAG_W-1:0] f_tag;
	logic [TW-1:0] f_nd;
	logic f_dv;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != msdt_pkg::S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign last_step  = (cnt_q == IW'(msdt_pkg::SLOTS - 1));
	assign dl_sum     = {1'b0, now} + {1'b0, delay};
	assign rl_sum     = {1'b0, now_q} + {1'b0, head.period};
	assign reload     = rl_sum[TW] ? {TW{1'b1}} : rl_sum[TW-1:0];
	assign emit_final = (state_q == msdt_pkg::S_FINAL) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msdt_pkg::S_IDLE:  if (accept) state_d = msdt_pkg::S_SCAN;
			msdt_pkg::S_SCAN:  if (step && last_step) state_d = msdt_pkg::S_FINAL;
			msdt_pkg::S_FINAL: if (out_free) state_d = msdt_pkg::S_IDLE;
			default:           state_d = msdt_pkg::S_IDLE;
		endcase
	end

	// head processing
	always_comb begin
		wb   = head;
		fire = 1'b0;
		hit  = 1'b0;
		case (act_q)
			msdt_pkg::ACT_ADD: if (!head.active && !found_q) begin
				hit = 1'b1;
				wb  = '{active: 1'b1, deadline: dl_q, period: period_q, tag: tag_q};
			end
			msdt_pkg::ACT_REMOVE: if (head.active && cnt_q == sel_q) begin
				hit       = 1'b1;
				wb.active = 1'b0;
			end
			msdt_pkg::ACT_RUN: if (head.active && head.deadline <= now_q) begin
				fire = 1'b1;
				if (head.period != '0) wb.deadline = reload;
				else wb.active = 1'b0;
			end
			msdt_pkg::ACT_NEXT: if (!cache_v_q && head.active &&
				(!found_q || head.deadline < min_q)) begin
				hit = 1'b1;
			end
			msdt_pkg::ACT_FIND: if (head.active && head.tag == tag_q && !found_q) begin
				hit = 1'b1;
			end
			default: ;
		endcase
		step  = (state_q == msdt_pkg::S_SCAN) && (!fire || out_free);
		shift = step;
	end

	// closing result
	always_comb begin
		f_status = msdt_pkg::ST_OK;
		f_slot   = '0;
		f_tag    = '0;
		f_nd     = '0;
		f_dv     = 1'b0;
		case (act_q)
			msdt_pkg::ACT_ADD: if (found_q) begin
				f_slot = idx_q;
				f_tag  = tag_q;
			end else begin
				f_status = msdt_pkg::ST_FULL;
			end
			msdt_pkg::ACT_REMOVE: if (found_q) f_slot = idx_q;
				else f_status = msdt_pkg::ST_NOT_ACTIVE;
			msdt_pkg::ACT_NEXT: if (cache_v_q) begin
				f_nd = cache_q;
				f_dv = 1'b1;
			end else if (found_q) begin
				f_nd = min_q;
				f_dv = 1'b1;
			end
			msdt_pkg::ACT_FIND: if (found_q) begin
				f_slot = idx_q;
				f_tag  = tag_q;
			end else begin
				f_status = msdt_pkg::ST_NOT_FOUND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msdt_pkg::S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			fired_any_q <= 1'b0;
			cache_v_q   <= 1'b0;
			cache_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				found_q     <= 1'b0;
				fired_any_q <= 1'b0;
				cnt_q       <= '0;
			end
			if (step) begin
				cnt_q <= cnt_q + IW'(1);
				if (hit) found_q <= 1'b1;
				if (fire) fired_any_q <= 1'b1;
			end
			if (emit_final) begin
				case (act_q)
					msdt_pkg::ACT_ADD:
						if (found_q && cache_v_q && dl_q <= cache_q) cache_q <= dl_q;
					msdt_pkg::ACT_RUN:
						if (fired_any_q) cache_v_q <= 1'b0;
					msdt_pkg::ACT_NEXT: if (!cache_v_q && found_q) begin
						cache_q   <= min_q;
						cache_v_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (out_free) out_valid_q <= (step && fire) || emit_final;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			now_q    <= now;
			dl_q     <= dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
			period_q <= period;
			sel_q    <= slot;
			tag_q    <= tag;
		end
		if (step && hit) begin
			idx_q <= cnt_q;
			min_q <= head.deadline;
		end
		if (step && fire) begin
			status_q   <= msdt_pkg::ST_OK;
			fired_q    <= 1'b1;
			slot_out_q <= cnt_q;
			tag_out_q  <= head.tag;
			nd_q       <= '0;
			dv_q       <= 1'b0;
			last_q     <= 1'b0;
		end else if (emit_final) begin
			status_q   <= f_status;
			fired_q    <= 1'b0;
			slot_out_q <= f_slot;
			tag_out_q  <= f_tag;
			nd_q       <= f_nd;
			dv_q       <= f_dv;
			last_q     <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign fired          = fired_q;
	assign slot_out       = slot_out_q;
	assign tag_out        = tag_out_q;
	assign next_deadline  = nd_q;
	assign deadline_valid = dv_q;
	assign last           = last_q;

	`ASSERT_IMP(a_idle_cnt, state_q == msdt_pkg::S_IDLE, cnt_q == '0)
	`ASSERT_IMP(a_fire_run, step && fire, act_q == msdt_pkg::ACT_RUN)
	`ASSERT_IMP(a_hold_why, state_q == msdt_pkg::S_SCAN && !step, out_valid_q && out_stall)
endmodule

FILE: hdl/multi_slot_deadline_timer_table.sv
// Top level: ring of timer slot cells plus the sequencer at its head.
//
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | action now delay period slot tag
//  output  | out_valid/out_stall| status fired slot_out tag_out next_deadline
//          |                    | deadline_valid last
//
// Every transaction rotates the whole ring once, one slot per cycle when the output
// is not stalled; a new item is taken only once the last one's closing result is registered.
// A run result that cannot be taken holds the ring where it is.
// Reset clears all active marks and the cache at once; no clearing pass.
module multi_slot_deadline_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] now,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	input  logic [3:0]  slot,
	input  logic [31:0] tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        fired,
	output logic [3:0]  slot_out,
	output logic [31:0] tag_out,
	output logic [31:0] next_deadline,
	output logic        deadline_valid,
	output logic        last
);
	msdt_pkg::slot_t ring_q [msdt_pkg::SLOTS];
	msdt_pkg::slot_t wb;
	logic shift;

	for (genvar i = 0; i < msdt_pkg::SLOTS; i++) begin : g_ring
		msdt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     ((i == msdt_pkg::SLOTS - 1) ? wb : ring_q[(i + 1) % msdt_pkg::SLOTS]),
			.q     (ring_q[i])
		);
	end

	msdt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.now           (now),
		.delay         (delay),
		.period        (period),
		.slot          (slot),
		.tag           (tag),
		.head          (ring_q[0]),
		.wb            (wb),
		.shift         (shift),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.fired         (fired),
		.slot_out      (slot_out),
		.tag_out       (tag_out),
		.next_deadline (next_deadline),
		.deadline_valid(deadline_valid),
		.last          (last)
	);
endmodule
